@@ rtl/lsh_pkg.sv @@
// ---------------------------------------------------------------------------
// lsh_pkg
// Shared types and constants for the light share hit position block.
// ---------------------------------------------------------------------------
package lsh_pkg;

  // Sample and grid geometry
  localparam int SAMPLE_BITS = 14;
  localparam int GRID_SIZE   = 12;
  localparam int COORD_BITS  = 4;

  // Divider geometry: den = 2*(a+b), num < 2^COORD_BITS * den
  localparam int DEN_W  = SAMPLE_BITS + 2;
  localparam int NUM_W  = DEN_W + COORD_BITS;
  localparam int STAGES = COORD_BITS;

  // 2*(GRID_SIZE-1)*a + a + b == (2*GRID_SIZE-1)*a + b
  localparam logic [NUM_W-1:0] GRID_MULT = NUM_W'(2 * GRID_SIZE - 1);

  // Number of sensor pairs handled side by side
  localparam int LANES = 4;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [COORD_BITS-1:0]  coord_t;

  typedef struct packed {
    sample_t top_north;
    sample_t top_east;
    sample_t top_south;
    sample_t top_west;
    sample_t bottom_north;
    sample_t bottom_east;
    sample_t bottom_south;
    sample_t bottom_west;
  } sample_item_t;

  typedef struct packed {
    coord_t top_x;
    coord_t top_y;
    coord_t bottom_x;
    coord_t bottom_y;
  } hit_item_t;

endpackage

@@ rtl/lsh_if.sv @@
// ---------------------------------------------------------------------------
// lsh_sample_if / lsh_hit_if
// Valid/ready channels for sample items in and hit items out.
// ---------------------------------------------------------------------------
interface lsh_sample_if;
  import lsh_pkg::*;

  logic         valid;
  logic         ready;
  sample_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lsh_hit_if;
  import lsh_pkg::*;

  logic      valid;
  logic      ready;
  hit_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/lsh_lane.sv @@
// ---------------------------------------------------------------------------
// lsh_lane
// One sensor pair: baseline correction, then a pipelined restoring divider
// that yields round((GRID_SIZE-1)*a/(a+b)), one quotient bit per stage.
// ---------------------------------------------------------------------------
module lsh_lane (
  input  logic             clk,
  input  logic             en,
  input  lsh_pkg::sample_t baseline,
  input  lsh_pkg::sample_t raw_a,
  input  lsh_pkg::sample_t raw_b,
  output lsh_pkg::coord_t  coord
);
  import lsh_pkg::*;

  sample_t          a_corr;
  sample_t          b_corr;
  logic [NUM_W-1:0] num_in;
  logic [DEN_W-1:0] den_in;

  logic [NUM_W-1:0] rem [0:STAGES-1];
  logic [DEN_W-1:0] den [0:STAGES-1];
  coord_t           q   [1:STAGES];

  // Baseline correction; at or below baseline clamps to 1
  always_comb begin
    a_corr = (raw_a <= baseline) ? SAMPLE_BITS'(1) : raw_a - baseline;
    b_corr = (raw_b <= baseline) ? SAMPLE_BITS'(1) : raw_b - baseline;
    num_in = NUM_W'(a_corr) * GRID_MULT + NUM_W'(b_corr);
    den_in = {(DEN_W - 1)'(a_corr) + (DEN_W - 1)'(b_corr), 1'b0};
  end

  // Entry register
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num_in;
      den[0] <= den_in;
    end
  end

  // Divider stages, most significant quotient bit first
  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    localparam int SH = COORD_BITS - 1 - g;

    logic [NUM_W-1:0] trial;
    logic [NUM_W-1:0] diff;
    logic             take;

    always_comb begin
      trial = NUM_W'(den[g]) << SH;
      take  = rem[g] >= trial;
      diff  = rem[g] - trial;
    end

    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          q[1] <= COORD_BITS'(take);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          q[g+1] <= {q[g][COORD_BITS-2:0], take};
        end
      end
    end

    if (g < STAGES - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem[g+1] <= take ? diff : rem[g];
          den[g+1] <= den[g];
        end
      end
    end
  end

  assign coord = q[STAGES];

endmodule

@@ rtl/light_share_hit_position.sv @@
// ---------------------------------------------------------------------------
// light_share_hit_position
// Hit position on two sensor planes from north/south and east/west shares.
// ---------------------------------------------------------------------------
// Pipeline: the entry register loads at the sample accept edge, then each lane
//   has one divider stage per quotient bit; hit valid follows the last stage.
// Throughput: one item per cycle; four lanes run in parallel and the whole
//   pipeline stalls only while the hit output is held by the consumer.
// Reset: rst (synchronous) empties the pipeline and sets baseline to 0.
module light_share_hit_position (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  lsh_pkg::sample_t   cfg_data,
  lsh_sample_if.sink         sample,
  lsh_hit_if.source          hit
);
  import lsh_pkg::*;

  localparam int DEPTH = STAGES + 1;

  sample_t     baseline;
  logic        advance;
  logic [DEPTH-1:0] vld;
  sample_t     lane_a [0:LANES-1];
  sample_t     lane_b [0:LANES-1];
  coord_t      lane_q [0:LANES-1];

  // Baseline register
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline <= '0;
    end else if (cfg_we) begin
      baseline <= cfg_data;
    end
  end

  // Pipeline moves unless a finished item is waiting
  assign advance      = !vld[DEPTH-1] || hit.ready;
  assign sample.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[DEPTH-2:0], sample.valid};
    end
  end

  // Lane inputs: north/south and east/west of each plane
  always_comb begin
    lane_a[0] = sample.data.top_north;
    lane_b[0] = sample.data.top_south;
    lane_a[1] = sample.data.top_east;
    lane_b[1] = sample.data.top_west;
    lane_a[2] = sample.data.bottom_north;
    lane_b[2] = sample.data.bottom_south;
    lane_a[3] = sample.data.bottom_east;
    lane_b[3] = sample.data.bottom_west;
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    lsh_lane u_lane (
      .clk      (clk),
      .en       (advance),
      .baseline (baseline),
      .raw_a    (lane_a[l]),
      .raw_b    (lane_b[l]),
      .coord    (lane_q[l])
    );
  end

  // Merge lane results into one hit item
  assign hit.valid         = vld[DEPTH-1];
  assign hit.data.top_x    = lane_q[0];
  assign hit.data.top_y    = lane_q[1];
  assign hit.data.bottom_x = lane_q[2];
  assign hit.data.bottom_y = lane_q[3];

endmodule

@@ verif/tb_light_share_hit_position.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_light_share_hit_position
// Drives sample items through the hit position block and compares every hit
// item with a local prediction of the baseline-corrected, half-up rounded
// north/south and east/west shares. It runs directed corner items first,
// then random phases at several baselines under changing idle patterns. One
// phase has a long consumer hold-off, so that the pipeline backs up.
// ---------------------------------------------------------------------------
module tb_light_share_hit_position;
  import lsh_pkg::*;

  localparam int          SAMPLE_MAX       = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned SETTLE_CYCLES    = 12;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT      = 4000;

  // Expected hit items, kept in order of sample acceptance
  class hit_tracker;
    sample_t   baseline;
    hit_item_t pending_hits[$];
    int unsigned mismatches;

    function new();
      baseline   = '0;
      mismatches = 0;
    endfunction

    // Sample minus pedestal; at or below the pedestal counts as 1
    function longint unsigned corrected(sample_t raw);
      if (raw <= baseline) return 1;
      return raw - baseline;
    endfunction

    // round((GRID_SIZE-1) * a / (a+b)), halves up, in exact integers
    function coord_t share_cell(sample_t a_raw, sample_t b_raw);
      longint unsigned a, b, sum;
      a   = corrected(a_raw);
      b   = corrected(b_raw);
      sum = a + b;
      return coord_t'((2 * (GRID_SIZE - 1) * a + sum) / (2 * sum));
    endfunction

    function hit_item_t hit_from_samples(sample_item_t s);
      hit_item_t h;
      h.top_x    = share_cell(s.top_north, s.top_south);
      h.top_y    = share_cell(s.top_east, s.top_west);
      h.bottom_x = share_cell(s.bottom_north, s.bottom_south);
      h.bottom_y = share_cell(s.bottom_east, s.bottom_west);
      return h;
    endfunction

    function void note_sample(sample_item_t s);
      pending_hits.push_back(hit_from_samples(s));
    endfunction

    function void check_coord(string field, coord_t want, coord_t got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_hit(hit_item_t got);
      hit_item_t want;
      if (pending_hits.size() == 0) begin
        $error("hit item with no expected item pending: %h", got);
        mismatches++;
        return;
      end
      want = pending_hits.pop_front();
      check_coord("top_x", want.top_x, got.top_x);
      check_coord("top_y", want.top_y, got.top_y);
      check_coord("bottom_x", want.bottom_x, got.bottom_x);
      check_coord("bottom_y", want.bottom_y, got.bottom_y);
    endfunction

    function int unsigned outstanding();
      return pending_hits.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_we;
  sample_t cfg_data;

  lsh_sample_if sample_ch ();
  lsh_hit_if    hit_ch ();

  hit_tracker  book = new();
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 63;
  bit          hold_request  = 1'b0;

  light_share_hit_position dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .sample   (sample_ch),
    .hit      (hit_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one sample item, with random idle cycles ahead of it
  task automatic send_sample(input sample_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= item;
    do @(posedge clk); while (!sample_ch.ready);
    book.note_sample(item);
  endtask

  // Stop offering and wait until every hit item is back
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_baseline(input sample_t value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    book.baseline = value;
  endtask

  function automatic sample_item_t make_item(int tn, int te, int ts, int tw,
                                             int bn, int be, int bs, int bw);
    sample_item_t s;
    s.top_north    = sample_t'(tn);
    s.top_east     = sample_t'(te);
    s.top_south    = sample_t'(ts);
    s.top_west     = sample_t'(tw);
    s.bottom_north = sample_t'(bn);
    s.bottom_east  = sample_t'(be);
    s.bottom_south = sample_t'(bs);
    s.bottom_west  = sample_t'(bw);
    return s;
  endfunction

  // Sample value biased toward the pedestal, the extremes and single bits
  function automatic sample_t pick_sample(sample_t base);
    int v;
    case ($urandom_range(7))
      0, 1, 2: v = $urandom_range(SAMPLE_MAX);
      3:       v = int'(base) + int'($urandom_range(4)) - 2;
      4:       v = $urandom_range(1) ? SAMPLE_MAX : 0;
      5:       v = $urandom_range(SAMPLE_MAX, base);
      6:       v = int'(base) + int'($urandom_range(40));
      default: v = 1 << $urandom_range(SAMPLE_BITS - 1);
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return sample_t'(v);
  endfunction

  function automatic sample_item_t random_item(sample_t base);
    sample_item_t s;
    s.top_north    = pick_sample(base);
    s.top_east     = pick_sample(base);
    s.top_south    = pick_sample(base);
    s.top_west     = pick_sample(base);
    s.bottom_north = pick_sample(base);
    s.bottom_east  = pick_sample(base);
    s.bottom_south = pick_sample(base);
    s.bottom_west  = pick_sample(base);
    // balanced pairs land on the half-way cell
    if ($urandom_range(7) == 0) begin
      s.top_south   = s.top_north;
      s.bottom_west = s.bottom_east;
    end
    return s;
  endfunction

  // One random phase at a fixed baseline; the block is idle on entry
  task automatic run_phase(input sample_t base, input int unsigned items,
                           input int unsigned s_pct, input int unsigned r_pct,
                           input bit long_hold);
    settle();
    write_baseline(base);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int unsigned i = 0; i < items; i++) begin
      if (long_hold && i == items / 3) hold_request = 1'b1;
      send_sample(random_item(base));
    end
  endtask

  // Hit consumer: random ready, plus one long hold-off on request
  initial begin : hit_sink
    int unsigned stall_left;
    stall_left = 0;
    hit_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        hit_ch.ready <= 1'b0;
      end else begin
        hit_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
      if (hit_ch.valid && hit_ch.ready) book.check_hit(hit_ch.data);
    end
  end

  // Ends the run when no item moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (rst) @(posedge clk);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((sample_ch.valid && sample_ch.ready) || (hit_ch.valid && hit_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[light_share_hit_position] ERROR");
    $finish;
  end

  initial begin : stimulus
    sample_ch.valid <= 1'b0;
    sample_ch.data  <= '0;
    cfg_we          <= 1'b0;
    cfg_data        <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items at the reset baseline of zero
    send_sample(make_item(0, 0, 0, 0, 0, 0, 0, 0));
    send_sample(make_item(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                          SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
    send_sample(make_item(SAMPLE_MAX, 0, 0, SAMPLE_MAX,
                          0, SAMPLE_MAX, SAMPLE_MAX, 0));
    // exact halves: 0.5, 10.5, 1.5 and 5.5 round up
    send_sample(make_item(1, 21, 21, 1, 3, 1, 19, 0));
    send_sample(make_item('h2AAA, 'h1555, 'h1555, 'h2AAA,
                          'h2AAA, 'h1555, 'h1555, 'h2AAA));
    send_sample(make_item('h1555, 'h2AAA, 'h2AAA, 'h1555,
                          'h1555, 'h2AAA, 'h2AAA, 'h1555));
    send_sample(make_item(1, 0, 0, 1, 2, 1, 1, 2));
    repeat (5) send_sample(random_item('0));

    // Directed items around a mid-range pedestal
    settle();
    write_baseline(sample_t'(5000));
    send_sample(make_item(5000, 5000, 5000, 5000, 5000, 5000, 5000, 5000));
    send_sample(make_item(4999, 4999, 4999, 4999, 0, 0, 0, 0));
    send_sample(make_item(5001, SAMPLE_MAX, 5000, 4999,
                          0, 5002, SAMPLE_MAX, 5001));
    send_sample(make_item(SAMPLE_MAX, 5000, 4999, SAMPLE_MAX,
                          5021, 5001, 5001, 5021));
    repeat (4) send_sample(random_item(sample_t'(5000)));

    // Random phases: sender-light idling, then receiver-light, then none
    run_phase(sample_t'($urandom_range(1023)), 230, 27, 63, 1'b0);
    run_phase(sample_t'(SAMPLE_MAX), 50, 27, 63, 1'b0);
    run_phase('0, 220, 63, 27, 1'b1);
    run_phase(sample_t'($urandom_range(SAMPLE_MAX)), 200, 63, 27, 1'b0);
    run_phase(sample_t'($urandom_range(255)), 230, 0, 0, 1'b0);
    run_phase(sample_t'($urandom_range(SAMPLE_MAX - 1, 8192)), 200, 0, 0, 1'b0);

    settle();
    if (book.mismatches == 0 && book.outstanding() == 0)
      $display("[light_share_hit_position] OK");
    else
      $display("[light_share_hit_position] ERROR");
    $finish;
  end

endmodule
